/* sv/bspline_curve_de_boor_eval_defines.svh */
// assertion macros for the b-spline evaluator checker
`ifndef BSPLINE_CURVE_DE_BOOR_EVAL_DEFINES_SVH
`define BSPLINE_CURVE_DE_BOOR_EVAL_DEFINES_SVH
// implication checked at every clock outside reset
`define BSP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define BSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* sv/bsp_pkg.sv */
// shared types and constants of the b-spline evaluator
package bsp_pkg;
  localparam int MAX_POINTS_DEF = 64;
  localparam int MAX_DEGREE_DEF = 7;
  localparam int KW = 24;
  localparam int CW = 32;
  localparam int AW = 24;

  localparam logic [1:0] REQ_KNOT  = 2'd0;
  localparam logic [1:0] REQ_POINT = 2'd1;
  localparam logic [1:0] REQ_EVAL  = 2'd2;

  localparam logic REG_DEGREE = 1'b0;
  localparam logic REG_NPTS   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_LAST, S_LAST_W, S_SRCH, S_SRCH_W, S_LOAD, S_LOAD_W,
    S_KLO, S_KHI, S_KHI_W, S_DIV, S_BLEND, S_DONE
  } state_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic [KW:0] num;
    logic [KW:0] den;
  } div_req_t;
endpackage

/* sv/bsp_div.sv */
// restoring divider for alpha = num * 2^24 / den, clamped
module bsp_div (
  input  logic clk,
  input  logic rst,
  input  bsp_pkg::div_req_t req,
  output logic done,
  output logic [bsp_pkg::AW:0] alpha
);
  import bsp_pkg::*;
  logic [KW:0] rem;
  logic [KW:0] den;
  logic [AW-1:0] quo;
  logic [4:0] cnt;
  logic busy;
  logic quick;
  logic [KW+1:0] trial;

  assign trial = {rem, 1'b0} - {1'b0, den};

  // clamped cases finish without iterating
  assign quick = req.den[KW] || req.den == '0 || req.num[KW] || req.num == '0 ||
                 req.num >= req.den;

  // one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= req.start ? quick : (busy && cnt == 5'd1);
      if (req.start) begin
        den <= req.den;
        quo <= '0;
        if (req.den[KW] || req.den == '0 || req.num[KW] || req.num == '0) begin
          alpha <= '0;
        end else if (req.num >= req.den) begin
          alpha <= {1'b1, {AW{1'b0}}};
        end else begin
          rem <= req.num;
          cnt <= 5'(AW);
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (!trial[KW+1]) begin
          rem <= trial[KW:0];
          quo <= {quo[AW-2:0], 1'b1};
        end else begin
          rem <= {rem[KW-1:0], 1'b0};
          quo <= {quo[AW-2:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          alpha <= {1'b0, quo[AW-2:0], !trial[KW+1]};
        end
      end
    end
  end
endmodule

/* sv/bsp_blend.sv */
// registered fixed point blend of two coordinates
module bsp_blend (
  input  logic clk,
  input  logic signed [bsp_pkg::CW-1:0] left,
  input  logic signed [bsp_pkg::CW-1:0] right,
  input  logic [bsp_pkg::AW:0] alpha,
  output logic signed [bsp_pkg::CW-1:0] res
);
  import bsp_pkg::*;
  logic signed [CW+AW+1:0] pl;
  logic signed [CW+AW+1:0] pr;
  logic signed [CW+AW+3:0] sum;

  // products registered, then summed and rounded
  always_ff @(posedge clk) begin
    pl <= (CW+AW+2)'(left) * $signed({1'b0, (AW+1)'((1 << AW)) - alpha});
    pr <= (CW+AW+2)'(right) * $signed({1'b0, alpha});
  end
  assign sum = (CW+AW+4)'(pl) + (CW+AW+4)'(pr) + (CW+AW+4)'(1 << (AW-1));
  assign res = sum[AW+CW-1:AW];
endmodule

/* sv/bspline_curve_de_boor_eval.sv */
// b-spline curve evaluator: knot and point stores, span search, de boor triangle
// An item is taken when start is high and busy is low. Knot and point writes
// give no result. An evaluate item gives one result strobe after a span
// search through the knot memory, a load of the control points and the
// triangle steps, each of which waits on the one-bit-a-cycle alpha divider.
// The result strobe lasts one cycle and cannot be stalled.
module bspline_curve_de_boor_eval #(
  parameter int MAX_POINTS = bsp_pkg::MAX_POINTS_DEF,
  parameter int MAX_DEGREE = bsp_pkg::MAX_DEGREE_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] req_type,
  input  logic [6:0] index,
  input  logic [23:0] knot_value,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic [23:0] t_value,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [6:0] cfg_data,
  output logic strobe,
  output logic signed [31:0] curve_x,
  output logic signed [31:0] curve_y,
  output logic error_flag
);
  import bsp_pkg::*;
  localparam int KD = MAX_POINTS + MAX_DEGREE + 1;
  localparam int KIW = $clog2(KD);
  localparam int PIW = $clog2(MAX_POINTS);
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int NW = $clog2(MAX_POINTS + 1);

  logic [KW-1:0] kmem [KD];
  logic [CW-1:0] xmem [MAX_POINTS];
  logic [CW-1:0] ymem [MAX_POINTS];
  logic [CW-1:0] wx [MAX_DEGREE+1];
  logic [CW-1:0] wy [MAX_DEGREE+1];

  logic [2:0] degree;
  logic [6:0] num_points;
  state_t state, state_next;
  logic [KW-1:0] t, kq, klo;
  logic [CW-1:0] xq, yq;
  logic [KIW-1:0] kaddr;
  logic [PIW-1:0] paddr;
  logic [NW:0] j;
  logic [DW-1:0] r, jj, p;
  logic [NW-1:0] n;
  logic [NW:0] base;
  logic err;
  logic [AW:0] alpha;
  logic dv_done;
  div_req_t dreq;
  logic signed [CW-1:0] bx, by;
  logic bcnt;

  assign p = (degree > 3'(MAX_DEGREE)) ? DW'(MAX_DEGREE) : DW'(degree);
  assign n = (NW+1)'(num_points) > (NW+1)'(MAX_POINTS) ? NW'(MAX_POINTS) : NW'(num_points);
  assign busy = (state != S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= 3'd3;
      num_points <= 7'd4;
    end else if (cfg_we) begin
      if (cfg_index == REG_DEGREE) degree <= cfg_data[2:0];
      else num_points <= cfg_data;
    end
  end

  // memories: one write, one registered read each
  always_ff @(posedge clk) begin
    if (start && !busy && req_type == REQ_KNOT && 32'(index) < KD)
      kmem[KIW'(index)] <= knot_value;
    if (start && !busy && req_type == REQ_POINT && 32'(index) < MAX_POINTS) begin
      xmem[PIW'(index)] <= point_x;
      ymem[PIW'(index)] <= point_y;
    end
    kq <= kmem[kaddr];
    xq <= xmem[paddr];
    yq <= ymem[paddr];
  end

  // address selection
  always_comb begin
    kaddr = '0;
    paddr = PIW'(base + j + (NW+1)'(1));
    case (state)
      S_LAST: kaddr = KIW'(n + NW'(p));
      S_SRCH: kaddr = KIW'(j);
      S_LOAD: paddr = PIW'(j - (NW+1)'(1) - (NW+1)'(p));
      S_KLO: kaddr = KIW'(base + (NW+1)'(jj));
      S_KHI: kaddr = KIW'(base + (NW+1)'(jj) + (NW+1)'(p + 1 - r));
      default: kaddr = '0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start && req_type == REQ_EVAL) state_next = S_LAST;
      S_LAST: state_next = S_LAST_W;
      S_LAST_W: state_next = S_SRCH;
      S_SRCH: state_next = (j == (NW+1)'(n)) ? S_LOAD : S_SRCH_W;
      S_SRCH_W: state_next = (t < kq) ? S_LOAD : S_SRCH;
      S_LOAD: state_next = (err || j == '0 || j - (NW+1)'(1) < (NW+1)'(p)) ?
                           S_DONE : S_LOAD_W;
      S_LOAD_W: state_next = (j == (NW+1)'(p)) ? ((p == '0) ? S_DONE : S_KLO) : S_LOAD_W;
      S_KLO: state_next = S_KHI;
      S_KHI: state_next = S_KHI_W;
      S_KHI_W: state_next = S_DIV;
      S_DIV: if (dv_done) state_next = S_BLEND;
      S_BLEND: if (bcnt) state_next = (jj == r && r == p) ? S_DONE : S_KLO;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // divider request
  always_comb begin
    dreq.start = (state == S_KHI_W);
    dreq.num = {1'b0, t} - {1'b0, klo};
    dreq.den = {1'b0, kq} - {1'b0, klo};
  end

  bsp_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(dv_done), .alpha(alpha));
  bsp_blend u_bx (.clk(clk), .left(wx[jj - DW'(1)]), .right(wx[jj]), .alpha(alpha),
                  .res(bx));
  bsp_blend u_by (.clk(clk), .left(wy[jj - DW'(1)]), .right(wy[jj]), .alpha(alpha),
                  .res(by));

  // datapath and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      state <= S_IDLE;
    end else begin
      strobe <= (state == S_DONE);
      state <= state_next;
      case (state)
        S_IDLE: begin
          t <= t_value;
          j <= '0;
        end
        S_LAST_W: err <= (t > kq);
        S_SRCH_W: if (!(t < kq)) j <= j + (NW+1)'(1);
        S_LOAD: begin
          if (j == '0 || j - (NW+1)'(1) < (NW+1)'(p)) err <= 1'b1;
          base <= j - (NW+1)'(1) - (NW+1)'(p);
          j <= '0;
        end
        S_LOAD_W: begin
          wx[DW'(j)] <= xq;
          wy[DW'(j)] <= yq;
          j <= j + (NW+1)'(1);
          r <= DW'(1);
          jj <= p;
          if (j == (NW+1)'(p)) begin
            curve_x <= xq;
            curve_y <= yq;
          end
        end
        S_KLO: bcnt <= 1'b0;
        S_KHI: klo <= kq;
        S_BLEND: begin
          bcnt <= 1'b1;
          if (bcnt) begin
            wx[jj] <= bx;
            wy[jj] <= by;
            curve_x <= bx;
            curve_y <= by;
            if (jj == r) begin
              r <= r + DW'(1);
              jj <= p;
            end else jj <= jj - DW'(1);
          end
        end
        S_DONE: begin
          error_flag <= err;
          if (err) begin
            curve_x <= '0;
            curve_y <= '0;
          end
        end
        default: ;
      endcase
    end
  end
  // control point load: paddr reads ahead during load wait
endmodule

/* sv/bsp_checker.sv */
// port-level checker of the b-spline evaluator, bound to the top level
`include "bspline_curve_de_boor_eval_defines.svh"
module bsp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic [1:0] req_type,
  input logic strobe,
  input logic error_flag,
  input logic signed [31:0] curve_x,
  input logic signed [31:0] curve_y
);
  import bsp_pkg::*;
  `BSP_ASSERT_IMPL(a_strobe_busy, clk, rst, strobe, !busy)
  `BSP_ASSERT_NEXT(a_strobe_single, clk, rst, strobe, !strobe)
  `BSP_ASSERT_IMPL(a_err_zero, clk, rst, strobe && error_flag, curve_x == 0 && curve_y == 0)
  `BSP_ASSERT_NEXT(a_write_idle, clk, rst, start && !busy && req_type != REQ_EVAL, !busy)
endmodule

bind bspline_curve_de_boor_eval bsp_checker u_chk (.*);
